@@ design/mldc_pkg.sv @@
`default_nettype none

package mldc_pkg;

   localparam int SENSORS_DEF          = 1;
   localparam int POLL_INTERVAL_MS_DEF = 200;

   localparam logic [31:0] OFF_DELAY_RESET = 32'd600000;
   localparam logic [7:0]  TEMP_MARK       = 8'd255;
   localparam logic [7:0]  PRESET_NONE     = 8'd0;

   localparam logic CMD_POLL   = 1'b0;
   localparam logic CMD_CHANGE = 1'b1;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_APPLY        = 3'd1,
      ACT_UNLOAD_APPLY = 3'd2,
      ACT_SAVE_APPLY   = 3'd3,
      ACT_RESTORE      = 3'd4,
      ACT_APPLY_TEMP   = 3'd5,
      ACT_OFF          = 3'd6
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OFF_DELAY        = 3'd0,
      REG_ON_PRESET        = 3'd1,
      REG_OFF_PRESET       = 3'd2,
      REG_NIGHT_ONLY       = 3'd3,
      REG_REPORT_ONLY      = 3'd4,
      REG_OFF_ONLY         = 3'd5,
      REG_CANCEL_ON_CHANGE = 3'd6,
      REG_SUPPRESS_OFF     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [31:0] off_delay_ms;
      logic [7:0]  on_preset;
      logic [7:0]  off_preset;
      logic        night_only;
      logic        report_only;
      logic        off_only;
      logic        cancel_on_change;
      logic        suppress_off;
   } cfg_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] now_ms;
      logic [7:0]  pin_levels;
      logic        enable;
      logic        is_daytime;
      logic        light_on;
      logic [7:0]  active_preset;
      logic [7:0]  active_playlist;
      logic        light_off_mode;
   } req_item_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  preset_number;
      logic        motion_report;
      logic        motion_value;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ design/motion_light_off_delay_controller.sv @@
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tuser cmd, req_tdata item fields
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata action, preset, report, value
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle sustained while the result side is not stalled; a request is
// held in the input register, then its result, after the decision logic, in the
// result register.
// Reset clears all control state and the configuration to its defaults.
// A stalled result holds in the result register; the input register still
// takes a new item whenever the result register can load.
// csr_ready is always high; each write is registered and takes effect in the next cycle.

module motion_light_off_delay_controller
   import mldc_pkg::*;
#(
   parameter int SENSORS          = SENSORS_DEF,
   parameter int POLL_INTERVAL_MS = POLL_INTERVAL_MS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [31:0] now_ms, [39:32] pin_levels, [40] enable, [41] is_daytime,
   // [42] light_on, [50:43] active_preset, [58:51] active_playlist,
   // [59] light_off_mode, [63:60] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  wire logic                  req_tuser,

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] action, [10:3] preset_number, [11] motion_report,
   // [12] motion_value, [15:13] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         load_ready;
   logic         item_fire;

   assign req_item.cmd             = req_tuser;
   assign req_item.now_ms          = req_tdata[31:0];
   assign req_item.pin_levels      = req_tdata[39:32];
   assign req_item.enable          = req_tdata[40];
   assign req_item.is_daytime      = req_tdata[41];
   assign req_item.light_on        = req_tdata[42];
   assign req_item.active_preset   = req_tdata[50:43];
   assign req_item.active_playlist = req_tdata[58:51];
   assign req_item.light_off_mode  = req_tdata[59];

   assign rsp_tdata = {3'b000, rsp_item.motion_value, rsp_item.motion_report,
                       rsp_item.preset_number, rsp_item.action};

   mldc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mldc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .down_ready (load_ready),
      .item_fire  (item_fire),
      .item       (item)
   );

   mldc_core #(
      .SENSORS          (SENSORS),
      .POLL_INTERVAL_MS (POLL_INTERVAL_MS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_fire (item_fire),
      .item      (item),
      .result    (result)
   );

   mldc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (item_fire),
      .result     (result),
      .load_ready (load_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (rsp_item)
   );

endmodule

`default_nettype wire

@@ design/mldc_csr.sv @@
`default_nettype none

module mldc_csr
   import mldc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output      cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_OFF_DELAY:        cfg_in.off_delay_ms     = csr_data;
            REG_ON_PRESET:        cfg_in.on_preset        = csr_data[7:0];
            REG_OFF_PRESET:       cfg_in.off_preset       = csr_data[7:0];
            REG_NIGHT_ONLY:       cfg_in.night_only       = csr_data[0];
            REG_REPORT_ONLY:      cfg_in.report_only      = csr_data[0];
            REG_OFF_ONLY:         cfg_in.off_only         = csr_data[0];
            REG_CANCEL_ON_CHANGE: cfg_in.cancel_on_change = csr_data[0];
            REG_SUPPRESS_OFF:     cfg_in.suppress_off     = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.off_delay_ms     <= OFF_DELAY_RESET;
         cfg_ff.on_preset        <= PRESET_NONE;
         cfg_ff.off_preset       <= PRESET_NONE;
         cfg_ff.night_only       <= 1'b0;
         cfg_ff.report_only      <= 1'b0;
         cfg_ff.off_only         <= 1'b0;
         cfg_ff.cancel_on_change <= 1'b0;
         cfg_ff.suppress_off     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mldc_in_reg.sv @@
`default_nettype none

module mldc_in_reg
   import mldc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output      logic         in_ready,
   input  wire req_item_type in_item,
   input  wire logic         down_ready,
   output      logic         item_fire,
   output      req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign item_fire = valid_ff && down_ready;
   assign in_ready  = !valid_ff || down_ready;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload loads on every transfer, no reset needed
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ design/mldc_core.sv @@
`default_nettype none

module mldc_core
   import mldc_pkg::*;
#(
   parameter int SENSORS          = SENSORS_DEF,
   parameter int POLL_INTERVAL_MS = POLL_INTERVAL_MS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         item_fire,
   input  wire req_item_type item,
   output      rsp_item_type result
);

   localparam logic [31:0] POLL_IV = 32'(POLL_INTERVAL_MS);

   logic [SENSORS-1:0] sampled_ff, sampled_in;
   logic               triggered_ff, triggered_in;
   logic               timer_running_ff, timer_running_in;
   logic [31:0]        timer_start_ff, timer_start_in;
   logic [31:0]        last_poll_ff, last_poll_in;
   logic [7:0]         saved_playlist_ff, saved_playlist_in;
   logic [7:0]         saved_preset_ff, saved_preset_in;

   logic [SENSORS-1:0] levels;
   logic [SENSORS-1:0] changed;
   logic [SENSORS-1:0] rose;
   logic [31:0]        since_poll;
   logic [31:0]        elapsed;
   logic               poll_go;
   logic               timeout;
   logic               gate_on;
   logic               gate_off;
   logic               drive_on;
   logic               drive_off;
   logic               drive_blocked;
   logic               shows_on;

   assign levels     = item.pin_levels[SENSORS-1:0];
   assign changed    = levels ^ sampled_ff;
   assign rose       = changed & levels;
   assign since_poll = item.now_ms - last_poll_ff;
   assign elapsed    = item.now_ms - timer_start_ff;

   assign poll_go = item_fire && (item.cmd == CMD_POLL) && item.enable &&
                    (since_poll >= POLL_IV);
   assign timeout = timer_running_ff && (elapsed > cfg.off_delay_ms);

   assign gate_on  = !cfg.report_only && (!cfg.night_only || !item.is_daytime);
   assign gate_off = !cfg.report_only &&
                     (!cfg.night_only || !item.is_daytime || triggered_ff);

   assign drive_on  = poll_go && (|changed) && (|rose) && gate_on;
   assign drive_off = poll_go && !(|changed) && timeout && gate_off;

   // off-only mode leaves a lit light alone unless it was triggered here; a triggered light is not switched on twice
   assign drive_blocked =
      (cfg.off_only && item.light_on && (drive_on || !triggered_ff)) ||
      (triggered_ff && drive_on);

   assign shows_on = (item.active_preset == cfg.on_preset) ||
                     (item.active_playlist == cfg.on_preset);

   always_comb begin
      sampled_in        = sampled_ff;
      triggered_in      = triggered_ff;
      timer_running_in  = timer_running_ff;
      timer_start_in    = timer_start_ff;
      last_poll_in      = last_poll_ff;
      saved_playlist_in = saved_playlist_ff;
      saved_preset_in   = saved_preset_ff;
      result            = '{ACT_NONE, PRESET_NONE, 1'b0, 1'b0};

      if (item_fire && (item.cmd == CMD_CHANGE)) begin
         if (cfg.cancel_on_change && triggered_ff && timer_running_ff) begin
            timer_running_in = 1'b0;
            triggered_in     = 1'b0;
         end
      end

      if (poll_go) begin
         last_poll_in = item.now_ms;
         sampled_in   = levels;
         if (|changed) begin
            if (|rose) begin
               timer_running_in = 1'b0;
            end else begin
               timer_running_in = 1'b1;
               timer_start_in   = item.now_ms;
            end
            result.motion_report = 1'b1;
            result.motion_value  = |rose;
         end else if (timeout) begin
            timer_running_in = 1'b0;
         end
      end

      if ((drive_on || drive_off) && !drive_blocked) begin
         triggered_in = drive_on;
         if (drive_on) begin
            if (cfg.on_preset != PRESET_NONE) begin
               result.preset_number = cfg.on_preset;
               if ((item.active_playlist != PRESET_NONE) && !item.light_off_mode) begin
                  saved_playlist_in = item.active_playlist;
                  result.action     = ACT_UNLOAD_APPLY;
               end else if ((item.active_preset != PRESET_NONE) &&
                            !item.light_off_mode) begin
                  saved_preset_in = item.active_preset;
                  result.action   = ACT_APPLY;
               end else begin
                  saved_playlist_in = PRESET_NONE;
                  saved_preset_in   = TEMP_MARK;
                  result.action     = ACT_SAVE_APPLY;
               end
            end else if (!item.light_on) begin
               result.action = ACT_RESTORE;
            end
         end else if (!cfg.suppress_off) begin
            if (cfg.off_preset != PRESET_NONE) begin
               result.action        = ACT_APPLY;
               result.preset_number = cfg.off_preset;
            end else if (saved_playlist_ff != PRESET_NONE) begin
               if (shows_on) begin
                  result.action        = ACT_APPLY;
                  result.preset_number = saved_playlist_ff;
               end
               saved_playlist_in = PRESET_NONE;
            end else if (saved_preset_ff != PRESET_NONE) begin
               if (shows_on) begin
                  if (saved_preset_ff != TEMP_MARK) begin
                     result.action        = ACT_APPLY;
                     result.preset_number = saved_preset_ff;
                  end else begin
                     result.action = ACT_APPLY_TEMP;
                  end
               end
               saved_preset_in = PRESET_NONE;
            end else if (item.light_on) begin
               result.action = ACT_OFF;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff        <= '0;
         triggered_ff      <= 1'b0;
         timer_running_ff  <= 1'b0;
         timer_start_ff    <= '0;
         last_poll_ff      <= '0;
         saved_playlist_ff <= PRESET_NONE;
         saved_preset_ff   <= PRESET_NONE;
      end else begin
         sampled_ff        <= sampled_in;
         triggered_ff      <= triggered_in;
         timer_running_ff  <= timer_running_in;
         timer_start_ff    <= timer_start_in;
         last_poll_ff      <= last_poll_in;
         saved_playlist_ff <= saved_playlist_in;
         saved_preset_ff   <= saved_preset_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mldc_out_reg.sv @@
`default_nettype none

module mldc_out_reg
   import mldc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_item_type result,
   output      logic         load_ready,
   output      logic         out_valid,
   input  wire logic         out_ready,
   output      rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

endmodule

`default_nettype wire

@@ design/mldc_checker.sv @@
`default_nettype none

module mldc_checker
   import mldc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tdata[11])
      else $error("motion value without motion report");

   // preset number only accompanies the apply actions
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ACT_APPLY) &&
      (rsp_tdata[2:0] != ACT_UNLOAD_APPLY) && (rsp_tdata[2:0] != ACT_SAVE_APPLY)
      |-> rsp_tdata[10:3] == PRESET_NONE)
      else $error("preset number with an action that takes none");

endmodule

bind motion_light_off_delay_controller mldc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
